// File: src/bple_pkg.sv
// Package for the button press LED effect block.
// Holds widths, effect and register codes, sequencer states and the divider interface types.
// Used by bple_div and button_press_led_effect.
package bple_pkg;

    localparam int LEVEL_W = 8;
    localparam int TICK_W  = 16;
    localparam int CNT_W   = 5;
    localparam int STEP_W  = 3;
    localparam int REM_W   = 2 * LEVEL_W + TICK_W - LEVEL_W + 2;
    localparam int PIX_W   = 3 * LEVEL_W;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;

    localparam logic [CNT_W-1:0] LOCKOUT_VALUE = 5'd22;

    localparam logic [2:0] MODE_OFF        = 3'd0;
    localparam logic [2:0] MODE_SOLID      = 3'd1;
    localparam logic [2:0] MODE_TOGGLE     = 3'd2;
    localparam logic [2:0] MODE_FADE       = 3'd3;
    localparam logic [2:0] MODE_INV_FADE   = 3'd4;
    localparam logic [2:0] MODE_LIT_IDLE   = 3'd5;
    localparam logic [2:0] MODE_LIT_PUSHED = 3'd6;

    localparam logic [IDX_W-1:0] REG_EFFECT_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_FADE_TICKS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_RED_LEVEL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_LEVEL = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_LEVEL  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_PRESS,
        ST_EMIT
    } bple_state_t;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] level;
        logic [TICK_W-1:0]  num;
        logic [TICK_W-1:0]  den;
    } bple_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bple_div_status_t;

endpackage

// File: src/bple_div.sv
// Shift-subtract unit computing round(level*num/den), half up, one quotient bit per cycle.
// Quotient fits in LEVEL_W bits since num never exceeds den. Depends on bple_pkg.
module bple_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bple_pkg::bple_div_req_t   req,
    output bple_pkg::bple_div_status_t status,
    output logic [7:0]                quotient
);
    import bple_pkg::*;

    logic [REM_W-1:0]   rem_reg;
    logic [TICK_W:0]    den2_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic               running_reg;
    logic               done_reg;

    logic [REM_W-1:0]   shifted;
    logic               ge;
    logic [REM_W-1:0]   dividend;

    assign dividend = ((REM_W'(req.level) * REM_W'(req.num)) << 1) + REM_W'(req.den);
    assign shifted  = REM_W'(den2_reg) << step_reg;
    assign ge       = rem_reg >= shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg     <= dividend;
                den2_reg    <= {req.den, 1'b0};
                step_reg    <= STEP_W'(LEVEL_W - 1);
                q_reg       <= '0;
                running_reg <= 1'b1;
            end else if (running_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - shifted;
                end
                q_reg[step_reg] <= ge;
                step_reg        <= step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    assign status.busy = running_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;

endmodule

// File: src/button_press_led_effect.sv
// Button press LED effect: top level with sequencer, registers and output stage.
// Each request passes press and emit states; in a fade the three channels are scaled in
// turn by the shared divider bple_div, each with a load and a divide state. A new request
// waits until the result is registered at the output. Synchronous active-low reset restores
// all register defaults, clears the press counter, LED state, fade position and pixel.
module button_press_led_effect #(
    parameter int PRESS_TICKS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_pin_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_press_event,
    output logic        m_led_on,
    output logic [7:0]  m_pixel_red,
    output logic [7:0]  m_pixel_green,
    output logic [7:0]  m_pixel_blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bple_pkg::*;

    bple_state_t state_reg, state_next;

    logic [2:0]         mode_reg;
    logic [TICK_W-1:0]  fade_ticks_reg;
    logic [LEVEL_W-1:0] red_reg, green_reg, blue_reg;
    logic [CNT_W-1:0]   press_counter_reg;
    logic               led_state_reg;
    logic [TICK_W-1:0]  fade_position_reg;
    logic [PIX_W-1:0]   pixel_reg;
    logic               event_reg;
    logic [1:0]         chan_reg;
    logic [TICK_W-1:0]  num_reg;
    logic               m_valid_reg;

    logic               s_fire, cfg_fire, out_free;
    logic [PIX_W-1:0]   base;
    logic               acc_led;
    logic [PIX_W-1:0]   acc_pixel;
    logic               acc_fading;
    logic [CNT_W-1:0]   acc_counter;
    logic               acc_event;
    logic               in_fade, fade_live;

    bple_div_req_t      div_req;
    bple_div_status_t   div_status;
    logic [7:0]         div_q;

    bple_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .status   (div_status),
        .quotient (div_q)
    );

    assign base     = {red_reg, green_reg, blue_reg};
    assign out_free = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_fade  = (mode_reg == MODE_FADE) || (mode_reg == MODE_INV_FADE);
    assign fade_live = fade_position_reg < fade_ticks_reg;

    // effect step and press counter for the request being taken
    always_comb begin
        acc_led    = led_state_reg;
        acc_pixel  = pixel_reg;
        acc_fading = 1'b0;
        case (mode_reg)
            MODE_LIT_IDLE: begin
                acc_led   = s_pin_level;
                acc_pixel = s_pin_level ? base : '0;
            end
            MODE_LIT_PUSHED: begin
                acc_led   = !s_pin_level;
                acc_pixel = s_pin_level ? '0 : base;
            end
            MODE_FADE, MODE_INV_FADE: begin
                if (fade_live) begin
                    acc_fading = 1'b1;
                end else begin
                    acc_led   = (mode_reg == MODE_INV_FADE);
                    acc_pixel = (mode_reg == MODE_INV_FADE) ? base : '0;
                end
            end
            default: begin
            end
        endcase

        if (!s_pin_level) begin
            acc_counter = press_counter_reg[CNT_W-1] ? press_counter_reg
                                                     : press_counter_reg + CNT_W'(1);
        end else begin
            acc_counter = '0;
        end
        acc_event = !acc_counter[CNT_W-1] && (acc_counter >= CNT_W'(PRESS_TICKS));
        if (acc_event) begin
            acc_counter = LOCKOUT_VALUE;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = acc_fading ? ST_LOAD : ST_PRESS;
                end
            end
            ST_LOAD:   state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (div_status.done) begin
                    state_next = (chan_reg == 2'd2) ? ST_PRESS : ST_LOAD;
                end
            end
            ST_PRESS:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cfg_ready     = (state_reg == ST_IDLE) && !s_valid;
        div_req.start = (state_reg == ST_LOAD);
        div_req.num   = num_reg;
        div_req.den   = fade_ticks_reg;
        case (chan_reg)
            2'd0:    div_req.level = red_reg;
            2'd1:    div_req.level = green_reg;
            default: div_req.level = blue_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_OFF;
            fade_ticks_reg    <= 16'd32;
            red_reg           <= 8'd255;
            green_reg         <= 8'd255;
            blue_reg          <= 8'd255;
            press_counter_reg <= '0;
            led_state_reg     <= 1'b0;
            fade_position_reg <= '0;
            pixel_reg         <= '0;
            event_reg         <= 1'b0;
            chan_reg          <= '0;
        end else begin
            if (cfg_fire) begin
                case (cfg_index)
                    REG_EFFECT_MODE: begin
                        mode_reg <= cfg_data[2:0];
                        if (cfg_data[2:0] inside {MODE_SOLID, MODE_INV_FADE, MODE_LIT_IDLE}) begin
                            led_state_reg <= 1'b1;
                            pixel_reg     <= base;
                        end else begin
                            led_state_reg <= 1'b0;
                            pixel_reg     <= '0;
                        end
                    end
                    REG_FADE_TICKS: fade_ticks_reg <= cfg_data;
                    REG_RED_LEVEL: begin
                        red_reg   <= cfg_data[7:0];
                        pixel_reg <= led_state_reg ? {cfg_data[7:0], green_reg, blue_reg} : '0;
                    end
                    REG_GREEN_LEVEL: begin
                        green_reg <= cfg_data[7:0];
                        pixel_reg <= led_state_reg ? {red_reg, cfg_data[7:0], blue_reg} : '0;
                    end
                    REG_BLUE_LEVEL: begin
                        blue_reg  <= cfg_data[7:0];
                        pixel_reg <= led_state_reg ? {red_reg, green_reg, cfg_data[7:0]} : '0;
                    end
                    default: begin
                    end
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        led_state_reg     <= acc_led;
                        pixel_reg         <= acc_pixel;
                        press_counter_reg <= acc_counter;
                        event_reg         <= acc_event;
                        chan_reg          <= '0;
                        num_reg           <= (mode_reg == MODE_INV_FADE) ? fade_position_reg
                                             : fade_ticks_reg - fade_position_reg;
                        if (acc_fading) begin
                            fade_position_reg <= fade_position_reg + TICK_W'(1);
                        end
                    end
                end
                ST_DIVIDE: begin
                    if (div_status.done) begin
                        case (chan_reg)
                            2'd0:    pixel_reg[23:16] <= div_q;
                            2'd1:    pixel_reg[15:8]  <= div_q;
                            default: pixel_reg[7:0]   <= div_q;
                        endcase
                        chan_reg <= chan_reg + 2'd1;
                    end
                end
                ST_PRESS: begin
                    if (event_reg) begin
                        case (mode_reg)
                            MODE_OFF: begin
                                led_state_reg <= 1'b0;
                                pixel_reg     <= '0;
                            end
                            MODE_SOLID: begin
                                led_state_reg <= 1'b1;
                                pixel_reg     <= base;
                            end
                            MODE_TOGGLE: begin
                                led_state_reg <= !led_state_reg;
                                pixel_reg     <= led_state_reg ? '0 : base;
                            end
                            MODE_FADE: begin
                                fade_position_reg <= '0;
                                led_state_reg     <= 1'b1;
                                pixel_reg         <= base;
                            end
                            MODE_INV_FADE: begin
                                fade_position_reg <= '0;
                                led_state_reg     <= 1'b0;
                                pixel_reg         <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_press_event <= event_reg;
            m_led_on      <= led_state_reg;
            m_pixel_red   <= pixel_reg[23:16];
            m_pixel_green <= pixel_reg[15:8];
            m_pixel_blue  <= pixel_reg[7:0];
        end
    end

    assign m_valid = m_valid_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg != ST_IDLE)
        else $error("sequencer idle right after a request was taken");

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide state");

    a_load_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> !div_status.busy && in_fade)
        else $error("divider started while busy or outside a fade");

    a_lockout_on_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRESS && event_reg) |-> press_counter_reg == LOCKOUT_VALUE)
        else $error("press reported without lockout");

endmodule

// File: tb/tb_top.sv
// Testbench for button_press_led_effect: per-tick pin samples with random valid/ready
// gaps, register writes between phases, every result checked against a built-in predictor.
// Depends on bple_pkg and the button_press_led_effect RTL.
module tb_top;
    import bple_pkg::*;

    localparam int PRESS_TICKS = 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] MODE_UNDEF = 3'd7;
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic               press;
        logic               led;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } tick_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_pin_level = 1'b1;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_press_event;
    logic               m_led_on;
    logic [7:0]         m_pixel_red;
    logic [7:0]         m_pixel_green;
    logic [7:0]         m_pixel_blue;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    // predictor registers and state
    logic [2:0]         mode_r = MODE_OFF;
    logic [TICK_W-1:0]  fade_len_r = 16'd32;
    logic [LEVEL_W-1:0] red_r = 8'hFF;
    logic [LEVEL_W-1:0] green_r = 8'hFF;
    logic [LEVEL_W-1:0] blue_r = 8'hFF;
    logic [CNT_W-1:0]   press_cnt = '0;
    logic               led_st = 1'b0;
    logic [TICK_W-1:0]  fade_pos = '0;
    logic [LEVEL_W-1:0] pix_red = '0;
    logic [LEVEL_W-1:0] pix_green = '0;
    logic [LEVEL_W-1:0] pix_blue = '0;

    bit                 pin_samples_q[$];
    tick_result_t       tick_results_q[$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    bit                 calm = 1'b0;
    bit                 hold_arm = 1'b0;
    bit                 hold_done = 1'b0;
    int                 hold_left = 0;

    button_press_led_effect #(.PRESS_TICKS(PRESS_TICKS)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pin_level  (s_pin_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_press_event(m_press_event),
        .m_led_on     (m_led_on),
        .m_pixel_red  (m_pixel_red),
        .m_pixel_green(m_pixel_green),
        .m_pixel_blue (m_pixel_blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic void set_led(input logic on);
        led_st = on;
        pix_red   = on ? red_r   : '0;
        pix_green = on ? green_r : '0;
        pix_blue  = on ? blue_r  : '0;
    endfunction

    // round(c * num / den), half up
    function automatic logic [LEVEL_W-1:0] fade_level(input logic [LEVEL_W-1:0] c,
                                                      input logic [TICK_W-1:0] num,
                                                      input logic [TICK_W-1:0] den);
        longint unsigned lc, ln, ld;
        lc = c;
        ln = num;
        ld = den;
        return LEVEL_W'((2 * lc * ln + ld) / (2 * ld));
    endfunction

    function automatic void fade_step(input logic inverse);
        logic [TICK_W-1:0] num;
        if (fade_pos < fade_len_r) begin
            num = inverse ? fade_pos : fade_len_r - fade_pos;
            pix_red   = fade_level(red_r, num, fade_len_r);
            pix_green = fade_level(green_r, num, fade_len_r);
            pix_blue  = fade_level(blue_r, num, fade_len_r);
            fade_pos  = fade_pos + TICK_W'(1);
        end else begin
            set_led(inverse);
        end
    endfunction

    function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
        case (idx)
            REG_EFFECT_MODE: begin
                mode_r = data[2:0];
                set_led(mode_r == MODE_SOLID || mode_r == MODE_INV_FADE ||
                        mode_r == MODE_LIT_IDLE);
            end
            REG_FADE_TICKS: fade_len_r = data;
            REG_RED_LEVEL: begin
                red_r = data[LEVEL_W-1:0];
                set_led(led_st);
            end
            REG_GREEN_LEVEL: begin
                green_r = data[LEVEL_W-1:0];
                set_led(led_st);
            end
            REG_BLUE_LEVEL: begin
                blue_r = data[LEVEL_W-1:0];
                set_led(led_st);
            end
            default: ;
        endcase
    endfunction

    function automatic tick_result_t predict_tick(input logic pin);
        tick_result_t res;
        case (mode_r)
            MODE_LIT_IDLE:   set_led(pin);
            MODE_LIT_PUSHED: set_led(!pin);
            MODE_FADE:       fade_step(1'b0);
            MODE_INV_FADE:   fade_step(1'b1);
            default: ;
        endcase
        if (!pin) begin
            if (!press_cnt[CNT_W-1])
                press_cnt = press_cnt + CNT_W'(1);
        end else begin
            press_cnt = '0;
        end
        res.press = 1'b0;
        if (!press_cnt[CNT_W-1] && press_cnt >= PRESS_TICKS) begin
            press_cnt = LOCKOUT_VALUE;
            res.press = 1'b1;
            case (mode_r)
                MODE_OFF:    set_led(1'b0);
                MODE_SOLID:  set_led(1'b1);
                MODE_TOGGLE: set_led(!led_st);
                MODE_FADE: begin
                    fade_pos = '0;
                    set_led(1'b1);
                end
                MODE_INV_FADE: begin
                    fade_pos = '0;
                    set_led(1'b0);
                end
                default: ;
            endcase
        end
        res.led   = led_st;
        res.red   = pix_red;
        res.green = pix_green;
        res.blue  = pix_blue;
        return res;
    endfunction

    function automatic void check_field(input string label, input logic [7:0] expv,
                                        input logic [7:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, expv, actv);
            mismatches++;
        end
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                tick_results_q.push_back(predict_tick(s_pin_level));
            if (!s_valid || s_ready) begin
                if (pin_samples_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
                    s_valid     <= 1'b1;
                    s_pin_level <= pin_samples_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tick_results_q.size() == 0) begin
                $display("%0t: result with no request pending", $time);
                mismatches++;
            end else begin
                want = tick_results_q.pop_front();
                check_field("press_event", want.press, m_press_event);
                check_field("led_on", want.led, m_led_on);
                check_field("pixel_red", want.red, m_pixel_red);
                check_field("pixel_green", want.green, m_pixel_green);
                check_field("pixel_blue", want.blue, m_pixel_blue);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
    endtask

    task automatic wait_idle();
        while (pin_samples_q.size() != 0 || s_valid || tick_results_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly clean presses (low run, then release), some single-tick noise
    task automatic queue_presses(input int count);
        int left, low_len, high_len;
        left = count;
        while (left > 0) begin
            if ($urandom_range(9) < 8) begin
                low_len  = ($urandom_range(7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
                high_len = $urandom_range(1, 5);
                repeat (low_len) pin_samples_q.push_back(1'b0);
                repeat (high_len) pin_samples_q.push_back(1'b1);
                left -= low_len + high_len;
            end else begin
                pin_samples_q.push_back(1'($urandom_range(1)));
                left--;
            end
        end
    endtask

    initial begin
        logic [2:0]        mode_list [8];
        logic [2:0]        mode_pick;
        logic [LEVEL_W-1:0] lvl;
        logic [TICK_W-1:0] len;
        mode_list = '{MODE_OFF, MODE_SOLID, MODE_TOGGLE, MODE_FADE, MODE_INV_FADE,
                      MODE_LIT_IDLE, MODE_LIT_PUSHED, MODE_UNDEF};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: colour extremes, unused indexes, modes with pin low, one press, lockout
        write_register(REG_RED_LEVEL, 16'hFFFF);
        write_register(REG_GREEN_LEVEL, 16'h0000);
        write_register(REG_BLUE_LEVEL, 16'h0081);
        write_register(REG_SPARE_A, 16'hFFFF);
        write_register(REG_SPARE_B, 16'h5A5A);
        for (int i = 0; i < 8; i++) begin
            if (mode_list[i] == MODE_FADE)
                write_register(REG_FADE_TICKS, 16'd1);
            if (mode_list[i] == MODE_INV_FADE)
                write_register(REG_FADE_TICKS, 16'd0);
            write_register(REG_EFFECT_MODE,
                           {((i % 2) == 1) ? 13'h1FFF : 13'h0000, mode_list[i]});
            pin_samples_q.push_back(1'b0);
            pin_samples_q.push_back(1'b0);
            pin_samples_q.push_back(1'b0);
            wait_idle();
        end
        write_register(REG_FADE_TICKS, 16'hFFFF);

        for (int ph = 0; ph < 12; ph++) begin
            calm = (ph == 5);
            if ($urandom_range(1)) begin
                case ($urandom_range(5))
                    0: len = 16'd0;
                    1: len = 16'd1;
                    2: len = 16'hFFFF;
                    default: len = TICK_W'($urandom_range(2, 40));
                endcase
                write_register(REG_FADE_TICKS, len);
            end
            for (int c = 0; c < 3; c++) begin
                if ($urandom_range(2) == 0) begin
                    case ($urandom_range(3))
                        0: lvl = 8'h00;
                        1: lvl = 8'hFF;
                        default: lvl = LEVEL_W'($urandom_range(255));
                    endcase
                    write_register(IDX_W'(REG_RED_LEVEL + c), {8'($urandom_range(255)), lvl});
                end
            end
            if ($urandom_range(4) != 0) begin
                case ($urandom_range(5))
                    0: mode_pick = MODE_FADE;
                    1: mode_pick = MODE_INV_FADE;
                    default: mode_pick = 3'($urandom_range(7));
                endcase
                write_register(REG_EFFECT_MODE, {13'($urandom_range(8191)), mode_pick});
            end
            if (ph == 2)
                hold_arm = 1'b1;
            queue_presses(95 + $urandom_range(10));
            wait_idle();
        end
        calm = 1'b0;

        repeat (100) @(posedge aclk);
        if (tick_results_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, tick_results_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
